// ----- src/pfs_pkg.sv -----
// Package for the PLL factor search block: field widths, search limits,
// the sequencer state type and the output-divider codes. No dependencies.
`default_nettype none

package pfs_pkg;

    // Field and datapath widths
    localparam int REF_W = 26;   // reference frequency
    localparam int TGT_W = 27;   // target frequency register
    localparam int VCO_W = 31;   // VCO frequency, divided ref at most 16 MHz times 86
    localparam int Q6_W  = 28;   // VCO / 6
    localparam int DQ_W  = 22;   // divided ref / 6
    localparam int N_W   = 7;
    localparam int M_W   = 4;
    localparam int CNT_W = 5;    // divider step counter

    // Divided ref / 6 by reciprocal multiplication; exact below 2**25
    localparam int DV6_IN_W     = 24;   // divided ref inside the 4..16 MHz window
    localparam int RECIP6_W     = 25;
    localparam int RECIP6_SHIFT = 27;
    localparam int DQ_PROD_W    = DV6_IN_W + RECIP6_W;

    // Search limits
    localparam logic [REF_W-1:0] DIV_MIN_HZ   = REF_W'(4000000);
    localparam logic [REF_W-1:0] DIV_MAX_HZ   = REF_W'(16000000);
    localparam logic [VCO_W-1:0] VCO_MIN_HZ   = VCO_W'(64000000);
    localparam logic [VCO_W-1:0] VCO_MAX_HZ   = VCO_W'(344000000);
    localparam logic [N_W-1:0]   N_FIRST      = N_W'(8);
    localparam logic [N_W-1:0]   N_LAST       = N_W'(86);
    localparam logic [M_W-1:0]   M_FIRST      = M_W'(1);
    localparam logic [M_W-1:0]   M_LAST       = M_W'(8);
    localparam logic [RECIP6_W-1:0] RECIP6    = RECIP6_W'(22369622);   // ceil(2**27 / 6)
    localparam logic [TGT_W-1:0] TARGET_RESET = TGT_W'(80000000);
    localparam logic [CNT_W-1:0] DV_LAST      = CNT_W'(REF_W - 1);

    // Results when nothing qualifies
    localparam logic [2:0]     DEF_M_CODE = 3'd1;
    localparam logic [N_W-1:0] DEF_N_MULT = N_W'(8);
    localparam logic [1:0]     DEF_R_CODE = 2'd0;

    // Output divider codes (R/2 - 1)
    localparam logic [1:0] R_CODE_DIV2 = 2'd0;
    localparam logic [1:0] R_CODE_DIV4 = 2'd1;
    localparam logic [1:0] R_CODE_DIV6 = 2'd2;
    localparam logic [1:0] R_CODE_DIV8 = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_M,
        ST_CHECK_M,
        ST_DIV_6,
        ST_INIT_N,
        ST_STEP_N,
        ST_EVAL_R,
        ST_NEXT_M,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ----- src/pll_factor_search.sv -----
// PLL factor search top level: sequencer plus one shared restoring divider
// and one shared compare/subtract unit. Depends on pfs_pkg.
//
// Usage: write the target frequency through i_cfg_we / i_cfg_wdata while the
// block is idle (reset value 80 MHz). Present a reference frequency with
// i_valid; it transfers when o_ready is high. The block then walks M = 1..8;
// for each M a bit-serial divider forms ref/M. If ref/M lies in 4..16 MHz,
// a reciprocal multiply forms (ref/M)/6 and, in the cycle after, its
// remainder; then N steps 0..86, one step per cycle unless an R evaluation
// holds it, accumulating the VCO and VCO/6 by addition. Each N of at least 8
// with the VCO in 64..344 MHz is evaluated for all four R values on the
// shared compare unit. o_ready stays low during the search. The result
// sits in an output register with o_valid until i_ready takes it; the next
// request may transfer while it waits, and a finished search holds in its
// last state while the previous result is still stalled. Reset (synchronous,
// active low) drops any search and pending result and restores the target.
`default_nettype none

module pll_factor_search (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [pfs_pkg::REF_W-1:0] i_ref_freq_hz,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [2:0]                     o_m_code,
    output logic [pfs_pkg::N_W-1:0]        o_n_mult,
    output logic [1:0]                     o_r_code,
    output logic                           o_found,
    input  wire logic                      i_cfg_we,
    input  wire logic [pfs_pkg::TGT_W-1:0] i_cfg_wdata
);
    import pfs_pkg::*;

    t_state r_state, n_state;

    logic [TGT_W-1:0] r_target;
    logic [REF_W-1:0] r_ref;
    logic [M_W-1:0]   r_m;
    logic [REF_W-1:0] r_div;

    // Shared divider
    logic [REF_W-1:0] r_dv_quo;
    logic [M_W-1:0]   r_dv_rem;
    logic [CNT_W-1:0] r_dv_cnt;
    logic [M_W-1:0]   dv_divisor;
    logic [M_W:0]     dv_trial;
    logic             dv_bit;
    logic [M_W-1:0]   dv_rem_next;

    // Divided ref / 6
    logic [DQ_PROD_W-1:0] dq_prod;
    logic [2:0]           dq_x6_lo;

    // N accumulation
    logic [N_W-1:0]   r_n;
    logic [VCO_W-1:0] r_vco;
    logic [Q6_W-1:0]  r_q6;
    logic [2:0]       r_rem6;
    logic [DQ_W-1:0]  r_dq;
    logic [2:0]       r_dr;
    logic [3:0]       rem6_sum;
    logic [2:0]       rem6_next;
    logic [Q6_W-1:0]  q6_next;
    logic             vco_ok;

    // Compare unit and best candidate
    logic [1:0]       r_ridx;
    logic [VCO_W-1:0] outf;
    logic [VCO_W:0]   diff;
    logic             cand_ok;
    logic             take;
    logic [TGT_W-1:0] r_best_gap;
    logic             r_found;
    logic [2:0]       r_m_sel;
    logic [N_W-1:0]   r_n_sel;
    logic [1:0]       r_r_sel;

    logic r_out_valid;
    logic in_xfer;
    logic div_ok;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign in_xfer = i_valid && o_ready;

    // Divider step: shift in the next dividend bit, subtract if it fits
    assign dv_divisor  = r_m;
    assign dv_trial    = {r_dv_rem, r_dv_quo[REF_W-1]};
    assign dv_bit      = (dv_trial >= {1'b0, dv_divisor});
    assign dv_rem_next = dv_bit ? M_W'(dv_trial - {1'b0, dv_divisor}) : M_W'(dv_trial);

    assign div_ok = (r_dv_quo >= DIV_MIN_HZ) && (r_dv_quo <= DIV_MAX_HZ);

    // Quotient by six from the reciprocal; remainder from the low bits
    assign dq_prod  = DQ_PROD_W'(r_div[DV6_IN_W-1:0]) * DQ_PROD_W'(RECIP6);
    assign dq_x6_lo = {r_dq[0], 2'b00} + {r_dq[1:0], 1'b0};

    // VCO/6 tracked as quotient and remainder
    assign rem6_sum  = {1'b0, r_rem6} + {1'b0, r_dr};
    assign rem6_next = (rem6_sum >= 4'd6) ? 3'(rem6_sum - 4'd6) : rem6_sum[2:0];
    assign q6_next   = r_q6 + Q6_W'(r_dq) + Q6_W'(rem6_sum >= 4'd6);
    assign vco_ok    = (r_n >= N_FIRST) && (r_vco >= VCO_MIN_HZ) && (r_vco <= VCO_MAX_HZ);

    // Select the output frequency for the current R and compare with the target
    always_comb begin
        unique case (r_ridx)
            R_CODE_DIV2: outf = r_vco >> 1;
            R_CODE_DIV4: outf = r_vco >> 2;
            R_CODE_DIV6: outf = VCO_W'(r_q6);
            R_CODE_DIV8: outf = r_vco >> 3;
            default:     outf = r_vco >> 1;
        endcase
    end

    assign diff    = {{(VCO_W-TGT_W+1){1'b0}}, r_target} - {1'b0, outf};
    assign cand_ok = !diff[VCO_W];
    assign take    = cand_ok && (!r_found || (diff[TGT_W-1:0] < r_best_gap));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (in_xfer) n_state = ST_DIV_M;
            ST_DIV_M:   if (r_dv_cnt == DV_LAST) n_state = ST_CHECK_M;
            ST_CHECK_M: n_state = div_ok ? ST_DIV_6 : ST_NEXT_M;
            ST_DIV_6:   n_state = ST_INIT_N;
            ST_INIT_N:  n_state = ST_STEP_N;
            ST_STEP_N: begin
                priority if (vco_ok)        n_state = ST_EVAL_R;
                else if (r_n == N_LAST)     n_state = ST_NEXT_M;
                else                        n_state = ST_STEP_N;
            end
            ST_EVAL_R: begin
                if (r_ridx == R_CODE_DIV8) begin
                    n_state = (r_n == N_LAST) ? ST_NEXT_M : ST_STEP_N;
                end
            end
            ST_NEXT_M:  n_state = (r_m == M_LAST) ? ST_FINISH : ST_DIV_M;
            ST_FINISH:  if (!r_out_valid || i_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // State register, target register and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_target    <= TARGET_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            priority if (r_state == ST_FINISH && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    r_ref      <= i_ref_freq_hz;
                    r_m        <= M_FIRST;
                    r_found    <= 1'b0;
                    r_best_gap <= '0;
                    r_m_sel    <= DEF_M_CODE;
                    r_n_sel    <= DEF_N_MULT;
                    r_r_sel    <= DEF_R_CODE;
                    r_dv_quo   <= i_ref_freq_hz;
                    r_dv_rem   <= '0;
                    r_dv_cnt   <= '0;
                end
            end
            ST_DIV_M: begin
                r_dv_quo <= {r_dv_quo[REF_W-2:0], dv_bit};
                r_dv_rem <= dv_rem_next;
                r_dv_cnt <= r_dv_cnt + CNT_W'(1);
            end
            ST_CHECK_M: begin
                // Hold ref/M for the N stepping
                r_div <= r_dv_quo;
            end
            ST_DIV_6: begin
                r_dq <= dq_prod[RECIP6_SHIFT +: DQ_W];
            end
            ST_INIT_N: begin
                r_dr   <= r_div[2:0] - dq_x6_lo;
                r_n    <= '0;
                r_vco  <= '0;
                r_q6   <= '0;
                r_rem6 <= '0;
                r_ridx <= R_CODE_DIV2;
            end
            ST_STEP_N: begin
                if (!vco_ok && r_n != N_LAST) begin
                    r_n    <= r_n + N_W'(1);
                    r_vco  <= r_vco + VCO_W'(r_div);
                    r_q6   <= q6_next;
                    r_rem6 <= rem6_next;
                end
            end
            ST_EVAL_R: begin
                if (take) begin
                    r_found    <= 1'b1;
                    r_best_gap <= diff[TGT_W-1:0];
                    r_m_sel    <= 3'(r_m - M_W'(1));
                    r_n_sel    <= r_n;
                    r_r_sel    <= r_ridx;
                end
                r_ridx <= r_ridx + 2'd1;
                // Advance N once all four R values are done
                if (r_ridx == R_CODE_DIV8 && r_n != N_LAST) begin
                    r_n    <= r_n + N_W'(1);
                    r_vco  <= r_vco + VCO_W'(r_div);
                    r_q6   <= q6_next;
                    r_rem6 <= rem6_next;
                end
            end
            ST_NEXT_M: begin
                if (r_m != M_LAST) begin
                    r_m      <= r_m + M_W'(1);
                    r_dv_quo <= r_ref;
                    r_dv_rem <= '0;
                    r_dv_cnt <= '0;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    o_m_code <= r_m_sel;
                    o_n_mult <= r_n_sel;
                    o_r_code <= r_r_sel;
                    o_found  <= r_found;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
